@@ design/gsts_pkg.sv @@
// Shared types, constants and codes for the gate servo and thrust slew limiter.
package gsts_pkg;

   // Field widths
   localparam int FUNC_W     = 3;
   localparam int ELAPSED_W  = 16;
   localparam int ANGLE_W    = 8;
   localparam int THRUST_W   = 12;
   localparam int RATE_W     = 16;
   localparam int RATE_FRAC  = 16;

   // Configuration bus
   localparam int PADDR_W    = 5;
   localparam int PDATA_W    = 32;
   localparam int REG_IDX_W  = 3;

   // Defaults for top level parameters
   localparam int NEUTRAL_THRUST_DEF = 1500;
   localparam int FRAC_BITS_DEF      = 16;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_OPEN  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SHOOT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SUCK  = 3'd4;

   // Thrust modes
   localparam logic [1:0] THRUST_OFF   = 2'd0;
   localparam logic [1:0] THRUST_SHOOT = 2'd1;
   localparam logic [1:0] THRUST_SUCK  = 2'd2;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_OPEN_ANGLE   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CLOSED_ANGLE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SHOOT_THRUST = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SUCK_THRUST  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SERVO_FAST   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SERVO_SLOW   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_THRUST_UP    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_THRUST_DOWN  = 3'd7;

   // Register reset values
   localparam logic [ANGLE_W-1:0]  RST_OPEN_ANGLE   = 8'd90;
   localparam logic [ANGLE_W-1:0]  RST_CLOSED_ANGLE = 8'd0;
   localparam logic [THRUST_W-1:0] RST_SHOOT_THRUST = 12'd2000;
   localparam logic [THRUST_W-1:0] RST_SUCK_THRUST  = 12'd1000;
   localparam logic [RATE_W-1:0]   RST_SERVO_FAST   = 16'd655;
   localparam logic [RATE_W-1:0]   RST_SERVO_SLOW   = 16'd65;
   localparam logic [RATE_W-1:0]   RST_THRUST_UP    = 16'd65;
   localparam logic [RATE_W-1:0]   RST_THRUST_DOWN  = 16'd655;

   typedef struct packed {
      logic [ANGLE_W-1:0]  open_angle;
      logic [ANGLE_W-1:0]  closed_angle;
      logic [THRUST_W-1:0] shoot_thrust;
      logic [THRUST_W-1:0] suck_thrust;
      logic [RATE_W-1:0]   servo_fast;
      logic [RATE_W-1:0]   servo_slow;
      logic [RATE_W-1:0]   thrust_up;
      logic [RATE_W-1:0]   thrust_down;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic                 manual_mode;
      logic [ELAPSED_W-1:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]  servo_angle;
      logic [THRUST_W-1:0] motor_thrust;
      logic                gate_is_open;
   } rsp_type;

endpackage

@@ design/gsts_if.sv @@
// Handshake channel interfaces for command/tick transactions and result transactions.
interface gsts_req_if import gsts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic                 manual_mode;
   logic [ELAPSED_W-1:0] elapsed_us;

   modport source (output valid, output func, output manual_mode, output elapsed_us,
                   input ready);
   modport sink (input valid, input func, input manual_mode, input elapsed_us,
                 output ready);
endinterface

interface gsts_rsp_if import gsts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ANGLE_W-1:0]  servo_angle;
   logic [THRUST_W-1:0] motor_thrust;
   logic                gate_is_open;

   modport source (output valid, output servo_angle, output motor_thrust,
                   output gate_is_open, input ready);
   modport sink (input valid, input servo_angle, input motor_thrust,
                 input gate_is_open, output ready);
endinterface

@@ design/gsts_csr.sv @@
// APB-style configuration register file.
module gsts_csr import gsts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[PADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_OPEN_ANGLE:   cfg_in.open_angle   = pwdata[ANGLE_W-1:0];
            REG_CLOSED_ANGLE: cfg_in.closed_angle = pwdata[ANGLE_W-1:0];
            REG_SHOOT_THRUST: cfg_in.shoot_thrust = pwdata[THRUST_W-1:0];
            REG_SUCK_THRUST:  cfg_in.suck_thrust  = pwdata[THRUST_W-1:0];
            REG_SERVO_FAST:   cfg_in.servo_fast   = pwdata[RATE_W-1:0];
            REG_SERVO_SLOW:   cfg_in.servo_slow   = pwdata[RATE_W-1:0];
            REG_THRUST_UP:    cfg_in.thrust_up    = pwdata[RATE_W-1:0];
            REG_THRUST_DOWN:  cfg_in.thrust_down  = pwdata[RATE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_angle   <= RST_OPEN_ANGLE;
         cfg_ff.closed_angle <= RST_CLOSED_ANGLE;
         cfg_ff.shoot_thrust <= RST_SHOOT_THRUST;
         cfg_ff.suck_thrust  <= RST_SUCK_THRUST;
         cfg_ff.servo_fast   <= RST_SERVO_FAST;
         cfg_ff.servo_slow   <= RST_SERVO_SLOW;
         cfg_ff.thrust_up    <= RST_THRUST_UP;
         cfg_ff.thrust_down  <= RST_THRUST_DOWN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_OPEN_ANGLE:   prdata = PDATA_W'(cfg_ff.open_angle);
         REG_CLOSED_ANGLE: prdata = PDATA_W'(cfg_ff.closed_angle);
         REG_SHOOT_THRUST: prdata = PDATA_W'(cfg_ff.shoot_thrust);
         REG_SUCK_THRUST:  prdata = PDATA_W'(cfg_ff.suck_thrust);
         REG_SERVO_FAST:   prdata = PDATA_W'(cfg_ff.servo_fast);
         REG_SERVO_SLOW:   prdata = PDATA_W'(cfg_ff.servo_slow);
         REG_THRUST_UP:    prdata = PDATA_W'(cfg_ff.thrust_up);
         REG_THRUST_DOWN:  prdata = PDATA_W'(cfg_ff.thrust_down);
         default:          prdata = '0;
      endcase
   end

endmodule

@@ design/gsts_slew.sv @@
// One slew channel: moves a fixed point value toward its target by at most elapsed * rate.
module gsts_slew import gsts_pkg::*; #(
   parameter int VAL_W     = 24,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic [VAL_W-1:0]     now,
   input  logic [VAL_W-1:0]     target,
   input  logic [ELAPSED_W-1:0] elapsed,
   input  logic [RATE_W-1:0]    rate,
   output logic [VAL_W-1:0]     next
);

   localparam int PROD_W = ELAPSED_W + RATE_W;
   localparam int SHL    = (FRAC_BITS >= RATE_FRAC) ? FRAC_BITS - RATE_FRAC : 0;
   localparam int SHR    = (FRAC_BITS >= RATE_FRAC) ? 0 : RATE_FRAC - FRAC_BITS;
   localparam int STEP_W = PROD_W + SHL;
   localparam int CMP_W  = ((STEP_W > VAL_W) ? STEP_W : VAL_W) + 1;

   logic [PROD_W-1:0] prod;
   logic [STEP_W-1:0] step;
   logic              up;
   logic [VAL_W-1:0]  delta;
   logic [VAL_W-1:0]  lim;

   // Per-tick limit, rescaled from 2^-16 units to the value's fraction bits
   assign prod = elapsed * rate;
   assign step = (STEP_W'(prod) << SHL) >> SHR;

   // Distance to target and clamp
   assign up    = (target >= now);
   assign delta = up ? target - now : now - target;
   assign lim   = (CMP_W'(delta) > CMP_W'(step)) ? VAL_W'(step) : delta;
   assign next  = up ? now + lim : now - lim;

endmodule

@@ design/gsts_core.sv @@
// Slew state, command decode and result rounding for one transaction per cycle while advance is high.
module gsts_core import gsts_pkg::*; #(
   parameter int NEUTRAL_THRUST = NEUTRAL_THRUST_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int AW = ANGLE_W + FRAC_BITS;
   localparam int TW = THRUST_W + FRAC_BITS;
   localparam logic [TW-1:0] NEUTRAL_FIX = TW'(NEUTRAL_THRUST) << FRAC_BITS;
   localparam logic [AW:0]   A_HALF      = (AW+1)'(1) << (FRAC_BITS - 1);
   localparam logic [TW:0]   T_HALF      = (TW+1)'(1) << (FRAC_BITS - 1);

   logic [AW-1:0] angle_ff,   angle_in;
   logic [TW-1:0] thrust_ff,  thrust_in;
   logic          open_ff,    open_in;
   logic [1:0]    mode_ff,    mode_in;
   logic          fast_ff,    fast_in;

   logic [AW-1:0]     open_fix;
   logic [AW-1:0]     a_tgt;
   logic [TW-1:0]     t_tgt;
   logic [RATE_W-1:0] s_rate;
   logic [RATE_W-1:0] t_rate;
   logic [TW-1:0]     tgt_dist;
   logic [TW-1:0]     now_dist;
   logic [AW-1:0]     angle_slew;
   logic [TW-1:0]     thrust_slew;
   logic [AW:0]       a_sum;
   logic [TW:0]       t_sum;
   logic [ANGLE_W:0]  a_round;
   logic [THRUST_W:0] t_round;

   // Targets and rates from the state as it stands before this transaction
   assign open_fix = AW'(cfg.open_angle) << FRAC_BITS;
   assign a_tgt    = open_ff ? open_fix : AW'(cfg.closed_angle) << FRAC_BITS;
   assign s_rate   = fast_ff ? cfg.servo_fast : cfg.servo_slow;

   always_comb begin
      case (mode_ff)
         THRUST_SHOOT: t_tgt = TW'(cfg.shoot_thrust) << FRAC_BITS;
         THRUST_SUCK:  t_tgt = TW'(cfg.suck_thrust) << FRAC_BITS;
         default:      t_tgt = NEUTRAL_FIX;
      endcase
   end

   // Up rate when the target lies farther from neutral than the thrust does
   assign tgt_dist = (t_tgt > NEUTRAL_FIX) ? t_tgt - NEUTRAL_FIX : NEUTRAL_FIX - t_tgt;
   assign now_dist = (thrust_ff > NEUTRAL_FIX) ? thrust_ff - NEUTRAL_FIX
                                               : NEUTRAL_FIX - thrust_ff;
   assign t_rate   = (tgt_dist > now_dist) ? cfg.thrust_up : cfg.thrust_down;

   gsts_slew #(.VAL_W(AW), .FRAC_BITS(FRAC_BITS)) u_angle_slew (
      .now     (angle_ff),
      .target  (a_tgt),
      .elapsed (item.elapsed_us),
      .rate    (s_rate),
      .next    (angle_slew)
   );

   gsts_slew #(.VAL_W(TW), .FRAC_BITS(FRAC_BITS)) u_thrust_slew (
      .now     (thrust_ff),
      .target  (t_tgt),
      .elapsed (item.elapsed_us),
      .rate    (t_rate),
      .next    (thrust_slew)
   );

   // Command decode
   always_comb begin
      angle_in  = angle_ff;
      thrust_in = thrust_ff;
      open_in   = open_ff;
      mode_in   = mode_ff;
      fast_in   = fast_ff;
      case (item.func)
         FUNC_TICK: begin
            angle_in  = angle_slew;
            thrust_in = thrust_slew;
         end
         FUNC_OPEN: begin
            fast_in = item.manual_mode;
            open_in = 1'b1;
         end
         FUNC_CLOSE: begin
            fast_in = 1'b1;
            open_in = 1'b0;
            mode_in = THRUST_OFF;
         end
         FUNC_SHOOT: begin
            fast_in = item.manual_mode;
            open_in = 1'b1;
            mode_in = THRUST_SHOOT;
         end
         FUNC_SUCK: begin
            open_in = 1'b1;
            mode_in = THRUST_SUCK;
         end
         default: begin
            angle_in = angle_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff  <= AW'(RST_CLOSED_ANGLE) << FRAC_BITS;
         thrust_ff <= NEUTRAL_FIX;
         open_ff   <= 1'b0;
         mode_ff   <= THRUST_OFF;
         fast_ff   <= 1'b0;
      end else if (advance) begin
         angle_ff  <= angle_in;
         thrust_ff <= thrust_in;
         open_ff   <= open_in;
         mode_ff   <= mode_in;
         fast_ff   <= fast_in;
      end
   end

   // Round half up and saturate, from the updated state
   assign a_sum   = {1'b0, angle_in} + A_HALF;
   assign t_sum   = {1'b0, thrust_in} + T_HALF;
   assign a_round = a_sum[AW:FRAC_BITS];
   assign t_round = t_sum[TW:FRAC_BITS];

   assign result.servo_angle  = a_round[ANGLE_W] ? '1 : a_round[ANGLE_W-1:0];
   assign result.motor_thrust = t_round[THRUST_W] ? '1 : t_round[THRUST_W-1:0];
   assign result.gate_is_open = open_in & (angle_in == open_fix);

endmodule

@@ design/gate_servo_thrust_slew_limiter.sv @@
// Top level of the gate servo and thrust slew limiter.
//
// Usage:
//  req_chan carries one transaction per command or time tick: func (tick,
//  open, close, shoot, suck), manual_mode and elapsed_us. Every accepted
//  transaction yields exactly one result on rsp_chan: the rounded servo angle,
//  the rounded motor thrust and the gate-open flag, in order.
//  Registers are written over the APB-style port (psel/penable/pwrite,
//  register i at byte address 4*i); write them only while the block is idle.
//  An accepted transaction is first held in the input register, then the
//  state update and result are registered together.
//  Throughput is one transaction per cycle unless the receiver stalls; the
//  per-cycle path is one 16x16 multiply per channel, then a clamp and an add.
//  When the receiver stalls, the result holds in the output register, the
//  next transaction waits in the input register, and req_chan.ready drops
//  once both are full.
//  Reset (synchronous, active high) restores register defaults, puts the
//  angle at the closed angle, the thrust at neutral, and empties both stages.
module gate_servo_thrust_slew_limiter import gsts_pkg::*; #(
   parameter int NEUTRAL_THRUST = NEUTRAL_THRUST_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   gsts_req_if.sink           req_chan,
   gsts_rsp_if.source         rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type cfg;
   req_type req_item;
   req_type item_ff;
   logic    in_vld_ff, in_vld_in;
   rsp_type result;
   rsp_type out_ff;
   logic    out_vld_ff, out_vld_in;
   logic    out_load;
   logic    advance;
   logic    req_take;

   gsts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake control
   assign out_load       = ~out_vld_ff | rsp_chan.ready;
   assign advance        = in_vld_ff & out_load;
   assign req_chan.ready = ~in_vld_ff | advance;
   assign req_take       = req_chan.valid & req_chan.ready;

   assign in_vld_in  = req_take | (in_vld_ff & ~advance);
   assign out_vld_in = advance | (out_vld_ff & ~rsp_chan.ready);

   assign req_item.func        = req_chan.func;
   assign req_item.manual_mode = req_chan.manual_mode;
   assign req_item.elapsed_us  = req_chan.elapsed_us;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_item;
      end
   end

   gsts_core #(.NEUTRAL_THRUST(NEUTRAL_THRUST), .FRAC_BITS(FRAC_BITS)) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.servo_angle  = out_ff.servo_angle;
   assign rsp_chan.motor_thrust = out_ff.motor_thrust;
   assign rsp_chan.gate_is_open = out_ff.gate_is_open;

endmodule
